// ===== rtl/mtxinv_pkg.sv =====
`default_nettype none
package mtxinv_pkg;

	// matrix entries, column-major: index = column * 3 + row
	localparam int NUM_ELEM = 9;
	localparam int THR_W = 17;

	// adjugate entry e = P - Q, with P = m[PA] * m[PB] and Q = m[QA] * m[QB]
	// (the negated cofactors already have their product pair swapped)
	localparam int ADJ_PA [NUM_ELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
	localparam int ADJ_PB [NUM_ELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
	localparam int ADJ_QA [NUM_ELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
	localparam int ADJ_QB [NUM_ELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

	// determinant: first row of the matrix times the first adjugate column
	localparam int DET_TERMS = 3;
	localparam int DET_M [DET_TERMS] = '{0, 3, 6};

	// diagonal positions of the identity
	localparam logic [NUM_ELEM-1:0] DIAG_MASK = 9'b100010001;

	// classification handed from front to back
	typedef struct packed {
		logic sing;
		logic neg_det;
	} cls_t;

endpackage
`default_nettype wire

// ===== rtl/mtxinv_queue.sv =====
`default_nettype none
module mtxinv_queue #(
	parameter int W = 8,
	parameter int AW = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] dout
);

	localparam int DEPTH = 1 << AW;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;
	logic          wr;
	logic          rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign dout  = mem_q[rd_q];

	// store the incoming transaction
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_q] <= din;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wr_q <= wr_q + 1'b1;
			end
			if (rd) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH))
		else $error("queue occupancy above depth");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == $past(cnt_q) + (AW+1)'($past(wr)) - (AW+1)'($past(rd)))
		else $error("queue occupancy lost a transaction");
`endif

endmodule
`default_nettype wire

// ===== rtl/mtxinv_front.sv =====
`default_nettype none
module mtxinv_front import mtxinv_pkg::*; #(
	parameter int DW = 32,
	parameter int FB = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [DW-1:0] ent [NUM_ELEM],
	input  logic [THR_W-1:0]     thr,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2*DW:0]        abs_n [NUM_ELEM],
	output logic [NUM_ELEM-1:0]  neg_n,
	output logic [3*DW:0]        mag,
	output cls_t                 cls
);

	localparam int NA   = 2 * DW + 1;
	localparam int DETW = 3 * DW + 2;
	localparam int MAGW = 3 * DW + 1;
	localparam int CMPW = (MAGW > THR_W + 2 * FB) ? MAGW : THR_W + 2 * FB;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic signed [DW-1:0]   ent_s1 [NUM_ELEM];
	logic signed [2*DW-1:0] pp_s2  [NUM_ELEM];
	logic signed [2*DW-1:0] qp_s2  [NUM_ELEM];
	logic signed [DW-1:0]   dm_s2  [DET_TERMS];
	logic signed [NA-1:0]   adj_s3 [NUM_ELEM];
	logic signed [DW-1:0]   dm_s3  [DET_TERMS];
	logic signed [NA-1:0]   adj_s4 [NUM_ELEM];
	logic signed [NA-1:0]   pl_s4  [DET_TERMS];
	logic signed [NA-1:0]   ph_s4  [DET_TERMS];
	logic signed [NA-1:0]   adj_s5 [NUM_ELEM];
	logic signed [DETW-1:0] prod_s5 [DET_TERMS];
	logic signed [NA-1:0]   adj_s6 [NUM_ELEM];
	logic signed [DETW-1:0] det_s6;
	logic [NA-1:0]          absn_s7 [NUM_ELEM];
	logic [NUM_ELEM-1:0]    negn_s7;
	logic [MAGW-1:0]        mag_s7;
	logic                   negd_s7;
	logic [NA-1:0]          absn_s8 [NUM_ELEM];
	logic [NUM_ELEM-1:0]    negn_s8;
	logic [MAGW-1:0]        mag_s8;
	logic                   negd_s8;
	logic                   sing_s8;

	// the whole front advances together unless its last stage is blocked
	assign en        = !v_s8 || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// capture the matrix
			ent_s1 <= ent;

			// cofactor products
			for (int e = 0; e < NUM_ELEM; e++) begin
				pp_s2[e] <= ent_s1[ADJ_PA[e]] * ent_s1[ADJ_PB[e]];
				qp_s2[e] <= ent_s1[ADJ_QA[e]] * ent_s1[ADJ_QB[e]];
			end
			for (int k = 0; k < DET_TERMS; k++) begin
				dm_s2[k] <= ent_s1[DET_M[k]];
			end

			// adjugate entries
			for (int e = 0; e < NUM_ELEM; e++) begin
				adj_s3[e] <= NA'(pp_s2[e]) - NA'(qp_s2[e]);
			end
			dm_s3 <= dm_s2;

			// determinant terms, each split into low and high partial products
			for (int k = 0; k < DET_TERMS; k++) begin
				pl_s4[k] <= dm_s3[k] * $signed({1'b0, adj_s3[k][DW-1:0]});
				ph_s4[k] <= dm_s3[k] * $signed(adj_s3[k][NA-1:DW]);
			end
			adj_s4 <= adj_s3;

			// recombine partial products
			for (int k = 0; k < DET_TERMS; k++) begin
				prod_s5[k] <= (DETW'(ph_s4[k]) <<< DW) + DETW'(pl_s4[k]);
			end
			adj_s5 <= adj_s4;

			// sum the determinant
			det_s6 <= prod_s5[0] + prod_s5[1] + prod_s5[2];
			adj_s6 <= adj_s5;

			// split into magnitudes and signs
			for (int e = 0; e < NUM_ELEM; e++) begin
				absn_s7[e] <= adj_s6[e][NA-1] ? NA'(-adj_s6[e]) : NA'(adj_s6[e]);
				negn_s7[e] <= adj_s6[e][NA-1];
			end
			mag_s7  <= det_s6[DETW-1] ? MAGW'(-det_s6) : MAGW'(det_s6);
			negd_s7 <= det_s6[DETW-1];

			// classify against the threshold
			absn_s8 <= absn_s7;
			negn_s8 <= negn_s7;
			mag_s8  <= mag_s7;
			negd_s8 <= negd_s7;
			sing_s8 <= (mag_s7 == '0) ||
				(CMPW'(mag_s7) < (CMPW'(thr) << (2 * FB)));
		end
	end

	assign abs_n       = absn_s8;
	assign neg_n       = negn_s8;
	assign mag         = mag_s8;
	assign cls.sing    = sing_s8;
	assign cls.neg_det = negd_s8;

endmodule
`default_nettype wire

// ===== rtl/mtxinv_back.sv =====
`default_nettype none
module mtxinv_back import mtxinv_pkg::*; #(
	parameter int DW = 32,
	parameter int FB = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2*DW:0]       abs_n [NUM_ELEM],
	input  logic [NUM_ELEM-1:0] neg_n,
	input  logic [3*DW:0]       mag,
	input  cls_t                cls,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DW-1:0]       res [NUM_ELEM],
	output logic                sing
);

	localparam int NA    = 2 * DW + 1;
	localparam int MAGW  = 3 * DW + 1;
	localparam int NUMW0 = NA + 2 * FB + 1;
	localparam int NUMW  = ((NUMW0 > MAGW) ? NUMW0 : MAGW) + 1;
	localparam int DENW  = MAGW + 1;
	localparam int RW    = (NUMW > DENW + DW) ? NUMW : DENW + DW;
	localparam logic [DW-1:0] POS_LIM = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] NEG_LIM = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] ONE_Q   = (FB >= DW - 1) ? POS_LIM : (DW'(1) << FB);

	logic en;

	// operand stage
	logic                v_b1;
	logic [RW-1:0]       num_b1 [NUM_ELEM];
	logic [RW-1:0]       den_b1;
	logic [NUM_ELEM-1:0] neg_b1;
	logic                sing_b1;

	// one quotient bit per step stage
	logic [DW-1:0]       v_st;
	logic [RW-1:0]       rem_st  [DW][NUM_ELEM];
	logic [DW-1:0]       q_st    [DW][NUM_ELEM];
	logic [NUM_ELEM-1:0] ovf_st  [DW];
	logic [RW-1:0]       den_st  [DW];
	logic [NUM_ELEM-1:0] neg_st  [DW];
	logic [DW-1:0]       sing_st;
	logic [RW-1:0]       rem_nx  [DW][NUM_ELEM];
	logic [DW-1:0]       q_nx    [DW][NUM_ELEM];
	logic [NUM_ELEM-1:0] ovf_nx;

	// saturated result stage
	logic                v_bf;
	logic [DW-1:0]       res_bf [NUM_ELEM];
	logic                sing_bf;
	logic [DW-1:0]       res_nx [NUM_ELEM];

	assign en        = !v_bf || out_ready;
	assign in_ready  = en;
	assign out_valid = v_bf;
	assign res       = res_bf;
	assign sing      = sing_bf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_st <= '0;
			v_bf <= 1'b0;
		end else if (en) begin
			v_b1 <= in_valid;
			v_st <= {v_st[DW-2:0], v_b1};
			v_bf <= v_st[DW-1];
		end
	end

	// restoring division steps, bit DW-1-t in stage t
	always_comb begin
		logic [RW-1:0] src;
		logic [RW-1:0] dsrc;
		logic [DW-1:0] qsrc;
		logic [RW-1:0] dsh;
		logic          ge;
		for (int e = 0; e < NUM_ELEM; e++) begin
			ovf_nx[e] = num_b1[e] >= (den_b1 << DW);
		end
		for (int t = 0; t < DW; t++) begin
			for (int e = 0; e < NUM_ELEM; e++) begin
				if (t == 0) begin
					src  = num_b1[e];
					dsrc = den_b1;
					qsrc = '0;
				end else begin
					src  = rem_st[t-1][e];
					dsrc = den_st[t-1];
					qsrc = q_st[t-1][e];
				end
				dsh = dsrc << (DW - 1 - t);
				ge  = src >= dsh;
				rem_nx[t][e] = ge ? src - dsh : src;
				q_nx[t][e]   = qsrc | (DW'(ge) << (DW - 1 - t));
			end
		end
	end

	// saturate and select the identity for singular matrices
	always_comb begin
		logic [DW-1:0] lim;
		logic [DW-1:0] mq;
		logic [DW-1:0] v;
		for (int e = 0; e < NUM_ELEM; e++) begin
			lim = neg_st[DW-1][e] ? NEG_LIM : POS_LIM;
			mq  = q_st[DW-1][e];
			v   = (ovf_st[DW-1][e] || mq > lim) ? lim : mq;
			if (sing_st[DW-1]) begin
				res_nx[e] = DIAG_MASK[e] ? ONE_Q : '0;
			end else begin
				res_nx[e] = neg_st[DW-1][e] ? DW'(-v) : v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// numerator 2|N|*2^(2F) + |D| over denominator 2|D|
			for (int e = 0; e < NUM_ELEM; e++) begin
				num_b1[e] <= RW'({abs_n[e], {(2*FB+1){1'b0}}}) + RW'(mag);
			end
			den_b1  <= RW'({mag, 1'b0});
			neg_b1  <= neg_n ^ {NUM_ELEM{cls.neg_det}};
			sing_b1 <= cls.sing;

			rem_st <= rem_nx;
			q_st   <= q_nx;
			for (int t = 0; t < DW; t++) begin
				if (t == 0) begin
					ovf_st[t]  <= ovf_nx;
					den_st[t]  <= den_b1;
					neg_st[t]  <= neg_b1;
					sing_st[t] <= sing_b1;
				end else begin
					ovf_st[t]  <= ovf_st[t-1];
					den_st[t]  <= den_st[t-1];
					neg_st[t]  <= neg_st[t-1];
					sing_st[t] <= sing_st[t-1];
				end
			end

			res_bf  <= res_nx;
			sing_bf <= sing_st[DW-1];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/matrix3_inverse.sv =====
`default_nettype none
// 3x3 matrix inverse by adjugate over determinant, signed fixed point.
// Input side: drive a matrix on col*_row* with push; it is taken
// on a clock edge where push is high and full is low. Result side is a
// queue: while empty is low the oldest inverse is on inv_* and singular;
// raise pop to take it. singular marks a determinant that is zero or whose
// magnitude is below the threshold, with the identity returned. cfg_data
// is written to the threshold on an edge where cfg_valid and cfg_ready are
// high; cfg_ready is always high, write only while no matrix is in flight.
// Throughput: one matrix per cycle while full stays low. On the way from
// the push edge to empty going low a matrix passes the eight-stage
// cofactor/determinant front, the two-entry queue between the parts and
// the bit-per-stage divider of DATA_WIDTH stages plus operand and
// saturation stages. When pop is held low the result queue fills, the
// divider pipeline stops, the middle queue fills and full rises; nothing
// is dropped. Reset clears both queues and all valid flags and sets the
// threshold to 1.
module matrix3_inverse import mtxinv_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [DATA_WIDTH-1:0] col0_row0,
	input  logic signed [DATA_WIDTH-1:0] col0_row1,
	input  logic signed [DATA_WIDTH-1:0] col0_row2,
	input  logic signed [DATA_WIDTH-1:0] col1_row0,
	input  logic signed [DATA_WIDTH-1:0] col1_row1,
	input  logic signed [DATA_WIDTH-1:0] col1_row2,
	input  logic signed [DATA_WIDTH-1:0] col2_row0,
	input  logic signed [DATA_WIDTH-1:0] col2_row1,
	input  logic signed [DATA_WIDTH-1:0] col2_row2,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [DATA_WIDTH-1:0] inv_col0_row0,
	output logic signed [DATA_WIDTH-1:0] inv_col0_row1,
	output logic signed [DATA_WIDTH-1:0] inv_col0_row2,
	output logic signed [DATA_WIDTH-1:0] inv_col1_row0,
	output logic signed [DATA_WIDTH-1:0] inv_col1_row1,
	output logic signed [DATA_WIDTH-1:0] inv_col1_row2,
	output logic signed [DATA_WIDTH-1:0] inv_col2_row0,
	output logic signed [DATA_WIDTH-1:0] inv_col2_row1,
	output logic signed [DATA_WIDTH-1:0] inv_col2_row2,
	output logic                         singular,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [THR_W-1:0]             cfg_data
);

	localparam int DW   = DATA_WIDTH;
	localparam int NA   = 2 * DW + 1;
	localparam int MAGW = 3 * DW + 1;
	localparam int CLSW = $bits(cls_t);
	localparam int MQW  = NUM_ELEM * NA + NUM_ELEM + MAGW + CLSW;
	localparam int OQW  = NUM_ELEM * DW + 1;
	localparam logic [DW-1:0] POS_LIM = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] ONE_Q   =
		(FRAC_BITS >= DW - 1) ? POS_LIM : (DW'(1) << FRAC_BITS);

	logic [THR_W-1:0]    threshold_q;
	logic signed [DW-1:0] ent [NUM_ELEM];

	logic                f_ready;
	logic                f_valid;
	logic [NA-1:0]       f_abs_n [NUM_ELEM];
	logic [NUM_ELEM-1:0] f_neg_n;
	logic [MAGW-1:0]     f_mag;
	cls_t                f_cls;

	logic                mq_full;
	logic                mq_empty;
	logic [MQW-1:0]      mq_din;
	logic [MQW-1:0]      mq_dout;

	logic                b_ready;
	logic [NA-1:0]       b_abs_n [NUM_ELEM];
	logic [NUM_ELEM-1:0] b_neg_n;
	logic [MAGW-1:0]     b_mag;
	cls_t                b_cls;
	logic                b_valid;
	logic [DW-1:0]       b_res [NUM_ELEM];
	logic                b_sing;

	logic                oq_full;
	logic [OQW-1:0]      oq_din;
	logic [OQW-1:0]      oq_dout;

	// hold the threshold register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	assign ent = '{col0_row0, col0_row1, col0_row2,
		col1_row0, col1_row1, col1_row2,
		col2_row0, col2_row1, col2_row2};
	assign full = !f_ready;

	mtxinv_front #(.DW(DW), .FB(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push),
		.in_ready  (f_ready),
		.ent       (ent),
		.thr       (threshold_q),
		.out_valid (f_valid),
		.out_ready (!mq_full),
		.abs_n     (f_abs_n),
		.neg_n     (f_neg_n),
		.mag       (f_mag),
		.cls       (f_cls)
	);

	// pack and unpack the middle queue transaction
	always_comb begin
		for (int e = 0; e < NUM_ELEM; e++) begin
			mq_din[e*NA +: NA] = f_abs_n[e];
		end
		mq_din[NUM_ELEM*NA +: NUM_ELEM]          = f_neg_n;
		mq_din[NUM_ELEM*NA + NUM_ELEM +: MAGW]   = f_mag;
		mq_din[MQW-1 -: CLSW]                    = f_cls;
	end

	always_comb begin
		for (int e = 0; e < NUM_ELEM; e++) begin
			b_abs_n[e] = mq_dout[e*NA +: NA];
		end
		b_neg_n = mq_dout[NUM_ELEM*NA +: NUM_ELEM];
		b_mag   = mq_dout[NUM_ELEM*NA + NUM_ELEM +: MAGW];
		b_cls   = cls_t'(mq_dout[MQW-1 -: CLSW]);
	end

	mtxinv_queue #(.W(MQW), .AW(1)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.full   (mq_full),
		.din    (mq_din),
		.pop    (b_ready),
		.empty  (mq_empty),
		.dout   (mq_dout)
	);

	mtxinv_back #(.DW(DW), .FB(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!mq_empty),
		.in_ready  (b_ready),
		.abs_n     (b_abs_n),
		.neg_n     (b_neg_n),
		.mag       (b_mag),
		.cls       (b_cls),
		.out_valid (b_valid),
		.out_ready (!oq_full),
		.res       (b_res),
		.sing      (b_sing)
	);

	always_comb begin
		for (int e = 0; e < NUM_ELEM; e++) begin
			oq_din[e*DW +: DW] = b_res[e];
		end
		oq_din[OQW-1] = b_sing;
	end

	mtxinv_queue #(.W(OQW), .AW(1)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_valid),
		.full   (oq_full),
		.din    (oq_din),
		.pop    (pop),
		.empty  (empty),
		.dout   (oq_dout)
	);

	assign inv_col0_row0 = oq_dout[0*DW +: DW];
	assign inv_col0_row1 = oq_dout[1*DW +: DW];
	assign inv_col0_row2 = oq_dout[2*DW +: DW];
	assign inv_col1_row0 = oq_dout[3*DW +: DW];
	assign inv_col1_row1 = oq_dout[4*DW +: DW];
	assign inv_col1_row2 = oq_dout[5*DW +: DW];
	assign inv_col2_row0 = oq_dout[6*DW +: DW];
	assign inv_col2_row1 = oq_dout[7*DW +: DW];
	assign inv_col2_row2 = oq_dout[8*DW +: DW];
	assign singular      = oq_dout[OQW-1];

`ifndef SYNTHESIS
	a_sing_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && singular) |->
		(inv_col1_row0 == '0 && inv_col1_row1 == ONE_Q && inv_col2_row1 == '0))
		else $error("singular result is not the identity");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> threshold_q == $past(cfg_data))
		else $error("threshold write lost");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import mtxinv_pkg::*;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam int LATENCY = DW + 11;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 200;

	typedef logic signed [DW-1:0] entry_t;
	typedef entry_t mat_t [NUM_ELEM];
	typedef struct {
		mat_t inv;
		logic sing;
	} inverse_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic empty;
	logic pop;
	logic cfg_valid;
	logic cfg_ready;
	logic [THR_W-1:0] cfg_data;
	entry_t a [NUM_ELEM];
	entry_t y [NUM_ELEM];
	logic singular;

	logic [THR_W-1:0] threshold;
	inverse_t expected_q [$];
	int mismatches;
	int matrices_sent;
	int inverses_seen;
	int singular_seen;
	int saturated_seen;
	int idle_cycles;
	bit hold_pop;
	bit random_pop_gaps;

	matrix3_inverse #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.col0_row0(a[0]), .col0_row1(a[1]), .col0_row2(a[2]),
		.col1_row0(a[3]), .col1_row1(a[4]), .col1_row2(a[5]),
		.col2_row0(a[6]), .col2_row1(a[7]), .col2_row2(a[8]),
		.empty(empty), .pop(pop),
		.inv_col0_row0(y[0]), .inv_col0_row1(y[1]), .inv_col0_row2(y[2]),
		.inv_col1_row0(y[3]), .inv_col1_row1(y[4]), .inv_col1_row2(y[5]),
		.inv_col2_row0(y[6]), .inv_col2_row1(y[7]), .inv_col2_row2(y[8]),
		.singular(singular),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// exact inverse: adjugate over determinant, rounded half away, saturated; identity when singular
	function automatic inverse_t compute_inverse(mat_t m, logic [THR_W-1:0] thr);
		inverse_t res;
		logic signed [255:0] e [NUM_ELEM];
		logic signed [255:0] adj [NUM_ELEM];
		logic signed [255:0] det;
		logic [255:0] mag, num, q, lim;
		logic [255:0] pos_max, neg_max;
		logic neg;
		pos_max = (256'd1 << (DW - 1)) - 1;
		neg_max = 256'd1 << (DW - 1);
		for (int i = 0; i < NUM_ELEM; i++)
			e[i] = m[i];
		// index = column * 3 + row
		adj[0] = e[4] * e[8] - e[7] * e[5];
		adj[1] = -(e[1] * e[8] - e[7] * e[2]);
		adj[2] = e[1] * e[5] - e[4] * e[2];
		adj[3] = -(e[3] * e[8] - e[6] * e[5]);
		adj[4] = e[0] * e[8] - e[6] * e[2];
		adj[5] = -(e[0] * e[5] - e[3] * e[2]);
		adj[6] = e[3] * e[7] - e[6] * e[4];
		adj[7] = -(e[0] * e[7] - e[6] * e[1]);
		adj[8] = e[0] * e[4] - e[3] * e[1];
		det = e[0] * adj[0] + e[3] * adj[1] + e[6] * adj[2];
		mag = det < 0 ? -det : det;
		lim = 256'(thr) << (2 * FB);
		if (det == 0 || mag < lim) begin
			for (int i = 0; i < NUM_ELEM; i++)
				res.inv[i] = DIAG_MASK[i] ? entry_t'(1 << FB) : '0;
			res.sing = 1'b1;
			return res;
		end
		for (int i = 0; i < NUM_ELEM; i++) begin
			neg = (adj[i] < 0) != (det < 0);
			num = adj[i] < 0 ? -adj[i] : adj[i];
			q = ((num << (2 * FB + 1)) + mag) / (mag << 1);
			if (neg)
				res.inv[i] = q > neg_max ? entry_t'(neg_max) : entry_t'(-q);
			else
				res.inv[i] = q > pos_max ? entry_t'(pos_max) : entry_t'(q);
		end
		res.sing = 1'b0;
		return res;
	endfunction

	function automatic entry_t rand_entry(int mode);
		case (mode)
			0: return entry_t'($urandom);
			1: return entry_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
			2: return entry_t'($signed($urandom_range(0, 32'h7ff)) - 32'sh3ff);
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return '0;
					default: return entry_t'(1 << FB);
				endcase
			end
		endcase
	endfunction

	// offer one matrix after a random gap, predict on acceptance;
	// push stays high so a following matrix can go back to back
	task automatic send_matrix(mat_t m, int max_gap);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		for (int i = 0; i < NUM_ELEM; i++)
			a[i] <= m[i];
		push <= 1'b1;
		do @(posedge clk); while (full);
		expected_q.push_back(compute_inverse(m, threshold));
		matrices_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] value);
		wait_drained();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		threshold = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed();
		mat_t m;
		for (int k = 0; k < 12; k++) begin
			for (int i = 0; i < NUM_ELEM; i++) begin
				case (k)
					0: m[i] = DIAG_MASK[i] ? entry_t'(1 << FB) : '0;
					1: m[i] = '0;
					2: m[i] = DIAG_MASK[i] ? 32'sh7fffffff : '0;
					3: m[i] = DIAG_MASK[i] ? 32'sh80000000 : '0;
					4: m[i] = DIAG_MASK[i] ? entry_t'(1) : '0;
					5: m[i] = DIAG_MASK[i] ? entry_t'(-(1 << FB)) : '0;
					6: m[i] = entry_t'(i * (1 << FB));
					7: m[i] = DIAG_MASK[i] ? entry_t'(3 << FB) : entry_t'(1 << FB);
					8: m[i] = i[0] ? 32'sh7fffffff : 32'sh80000000;
					9: m[i] = DIAG_MASK[i] ? entry_t'(2) : '0;
					10: m[i] = DIAG_MASK[i] ? entry_t'(-3) : entry_t'(1);
					default: m[i] = DIAG_MASK[i] ? 32'sh80000000 : 32'sh7fffffff;
				endcase
			end
			send_matrix(m, 2);
		end
	endtask

	task automatic test_random(int count, int mode);
		mat_t m;
		for (int k = 0; k < count; k++) begin
			for (int i = 0; i < NUM_ELEM; i++)
				m[i] = rand_entry(mode == 4 ? $urandom_range(0, 3) : mode);
			send_matrix(m, $urandom_range(0, 3) == 0 ? 0 : 10);
		end
	endtask

	// hold pop low for a counted stretch while matrices keep coming,
	// so every queue stage fills and push backs up
	task automatic test_backpressure();
		mat_t m;
		fork
			begin
				hold_pop = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_pop = 1'b0;
			end
			begin
				for (int k = 0; k < 80; k++) begin
					for (int i = 0; i < NUM_ELEM; i++)
						m[i] = rand_entry(1);
					send_matrix(m, 0);
				end
			end
		join
	endtask

	// drive pop: random gaps, a stretch with none, or held low
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pop)
				pop <= 1'b0;
			else if (!random_pop_gaps || $urandom_range(0, 10) == 0)
				pop <= 1'b1;
			else
				pop <= ($urandom_range(0, 10) < 4);
		end
	end

	// check each popped inverse against the oldest prediction
	always @(posedge clk) begin
		inverse_t exp_res;
		bit bad;
		if (arst_n && pop && !empty) begin
			inverses_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected inverse at %0t", $realtime);
			end else begin
				exp_res = expected_q.pop_front();
				bad = (singular !== exp_res.sing);
				for (int i = 0; i < NUM_ELEM; i++)
					if (y[i] !== exp_res.inv[i])
						bad = 1'b1;
				if (exp_res.sing)
					singular_seen++;
				else
					for (int i = 0; i < NUM_ELEM; i++)
						if (exp_res.inv[i] == 32'sh7fffffff || exp_res.inv[i] == 32'sh80000000)
							saturated_seen++;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("inverse %0d differs: singular exp %0b got %0b",
							inverses_seen, exp_res.sing, singular);
						for (int i = 0; i < NUM_ELEM; i++)
							$display("  [%0d] exp %h got %h", i, exp_res.inv[i], y[i]);
					end
				end
			end
		end
	end

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_valid || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("matrix3_inverse: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		for (int i = 0; i < NUM_ELEM; i++)
			a[i] = '0;
		threshold = 1;
		mismatches = 0;
		matrices_sent = 0;
		inverses_seen = 0;
		singular_seen = 0;
		saturated_seen = 0;
		idle_cycles = 0;
		hold_pop = 1'b0;
		random_pop_gaps = 1'b1;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random(300, 4);
		write_threshold('0);
		test_directed();
		test_random(200, 2);
		write_threshold(17'd65536);
		test_random(250, 1);
		write_threshold(17'h1ffff & 17'd65536);
		test_random(100, 0);
		write_threshold(17'd300);
		test_backpressure();
		random_pop_gaps = 1'b0;
		test_random(300, 2);
		random_pop_gaps = 1'b1;
		write_threshold(17'h0aaaa);
		test_random(250, 1);
		write_threshold(17'h15555);
		test_random(200, 4);
		write_threshold(17'd1);
		test_random(200, 0);
		wait_drained();

		$display("sent %0d matrices over 8 threshold settings; %0d inverses checked,",
			matrices_sent, inverses_seen);
		$display("%0d singular, %0d saturated entries, %0d errors",
			singular_seen, saturated_seen, mismatches);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("matrix3_inverse: match");
		else
			$display("matrix3_inverse: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
